[sv/sws_pkg.sv]
// Shared constants, operation codes and command type for the sliding window slope block.
package sws_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int TIME_W           = 32;
    localparam int VAL_W            = 16;
    localparam int SLOPE_W          = 48;
    localparam int FRAC_W           = 16;
    localparam int NUM_W            = 64;
    localparam int DVD_W            = NUM_W + FRAC_W;
    localparam int DCNT_W           = $clog2(DVD_W);
    localparam int MUL_W            = 33;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP       = 5'd0;
    localparam t_op OP_WRITE     = 5'd1;
    localparam t_op OP_READ      = 5'd2;
    localparam t_op OP_MUL_TY    = 5'd3;
    localparam t_op OP_MUL_TT    = 5'd4;
    localparam t_op OP_ACC       = 5'd5;
    localparam t_op OP_X_LO      = 5'd6;
    localparam t_op OP_X_HI      = 5'd7;
    localparam t_op OP_SQ_LL     = 5'd8;
    localparam t_op OP_SQ_HL     = 5'd9;
    localparam t_op OP_SQ_HH     = 5'd10;
    localparam t_op OP_NUM       = 5'd11;
    localparam t_op OP_DEN       = 5'd12;
    localparam t_op OP_DIV_LOAD  = 5'd13;
    localparam t_op OP_DIV_STEP  = 5'd14;
    localparam t_op OP_RES_ZERO  = 5'd15;
    localparam t_op OP_RES_DEGEN = 5'd16;
    localparam t_op OP_RES_SLOPE = 5'd17;

    typedef struct packed {
        t_op  op;
        logic full;
    } t_dp_cmd;

endpackage

[sv/sws_ctrl.sv]
// Controller state machine: handshakes, window index, and the sequence of datapath operations.
module sws_ctrl #(
    parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_clear,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_den_zero,
    output sws_pkg::t_dp_cmd                  o_cmd,
    output logic [$clog2(WINDOW_DEPTH)-1:0]   o_addr
);
    import sws_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(WINDOW_DEPTH - 1);
    localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(DVD_W - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_TY   = 4'd2;
    localparam logic [3:0] S_TT   = 4'd3;
    localparam logic [3:0] S_AC   = 4'd4;
    localparam logic [3:0] S_XLO  = 4'd5;
    localparam logic [3:0] S_XHI  = 4'd6;
    localparam logic [3:0] S_SQLL = 4'd7;
    localparam logic [3:0] S_SQHL = 4'd8;
    localparam logic [3:0] S_SQHH = 4'd9;
    localparam logic [3:0] S_NUM  = 4'd10;
    localparam logic [3:0] S_DEN  = 4'd11;
    localparam logic [3:0] S_CHK  = 4'd12;
    localparam logic [3:0] S_DIV  = 4'd13;
    localparam logic [3:0] S_RES  = 4'd14;

    localparam logic [1:0] K_ZERO  = 2'd0;
    localparam logic [1:0] K_DEGEN = 2'd1;
    localparam logic [1:0] K_SLOPE = 2'd2;

    logic [3:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_widx, n_widx;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic              r_filled, n_filled;
    logic [1:0]        r_kind, n_kind;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_widx      = r_widx;
        n_k         = r_k;
        n_dcnt      = r_dcnt;
        n_filled    = r_filled;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NOP;
        o_cmd.full  = r_filled;
        o_addr      = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind = K_ZERO;
                    if (i_in_clear) begin
                        n_widx   = '0;
                        n_filled = 1'b0;
                        n_state  = S_RES;
                    end else begin
                        o_cmd.op = OP_WRITE;
                        o_addr   = r_widx;
                        n_k      = '0;
                        if (r_widx == LAST_IDX) begin
                            n_widx   = '0;
                            n_filled = 1'b1;
                            n_state  = S_RD;
                        end else begin
                            n_widx  = r_widx + 1'b1;
                            n_state = r_filled ? S_RD : S_RES;
                        end
                    end
                end
            end
            S_RD: begin
                o_cmd.op = OP_READ;
                n_state  = S_TY;
            end
            S_TY: begin
                o_cmd.op = OP_MUL_TY;
                n_state  = S_TT;
            end
            S_TT: begin
                o_cmd.op = OP_MUL_TT;
                n_state  = S_AC;
            end
            S_AC: begin
                o_cmd.op = OP_ACC;
                if (r_k == LAST_IDX) begin
                    n_state = S_XLO;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RD;
                end
            end
            S_XLO: begin
                o_cmd.op = OP_X_LO;
                n_state  = S_XHI;
            end
            S_XHI: begin
                o_cmd.op = OP_X_HI;
                n_state  = S_SQLL;
            end
            S_SQLL: begin
                o_cmd.op = OP_SQ_LL;
                n_state  = S_SQHL;
            end
            S_SQHL: begin
                o_cmd.op = OP_SQ_HL;
                n_state  = S_SQHH;
            end
            S_SQHH: begin
                o_cmd.op = OP_SQ_HH;
                n_state  = S_NUM;
            end
            S_NUM: begin
                o_cmd.op = OP_NUM;
                n_state  = S_DEN;
            end
            S_DEN: begin
                o_cmd.op = OP_DEN;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.op = OP_DIV_LOAD;
                n_dcnt   = '0;
                if (i_den_zero) begin
                    n_kind  = K_DEGEN;
                    n_state = S_RES;
                end else begin
                    n_kind  = K_SLOPE;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_dcnt == LAST_STEP) begin
                    n_state = S_RES;
                end else begin
                    n_dcnt = r_dcnt + 1'b1;
                end
            end
            S_RES: begin
                if (out_free) begin
                    unique case (r_kind)
                        K_DEGEN: o_cmd.op = OP_RES_DEGEN;
                        K_SLOPE: o_cmd.op = OP_RES_SLOPE;
                        default: o_cmd.op = OP_RES_ZERO;
                    endcase
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_k         <= '0;
            r_dcnt      <= '0;
            r_filled    <= 1'b0;
            r_kind      <= K_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_widx      <= n_widx;
            r_k         <= n_k;
            r_dcnt      <= n_dcnt;
            r_filled    <= n_filled;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[sv/sws_dp.sv]
// Datapath: window memory, shared multiplier, sum accumulators, serial divider and result register.
module sws_dp #(
    parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  sws_pkg::t_dp_cmd                  i_cmd,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]   i_addr,
    input  logic [sws_pkg::TIME_W-1:0]        i_time,
    input  logic signed [sws_pkg::VAL_W-1:0]  i_value,
    output logic                              o_den_zero,
    output logic signed [sws_pkg::SLOPE_W-1:0] o_slope,
    output logic                              o_full,
    output logic                              o_degen
);
    import sws_pkg::*;

    localparam int LOGN   = $clog2(WINDOW_DEPTH);
    localparam int SUMT_W = TIME_W + LOGN;
    localparam int SUMY_W = VAL_W + LOGN;
    localparam int TT_W   = 2 * TIME_W + LOGN;
    localparam int DEN_W  = 2 * SUMT_W;
    localparam int HI_W   = SUMT_W - TIME_W;
    localparam logic [SLOPE_W-1:0] POS_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] NEG_MAX = {1'b1, {(SLOPE_W-1){1'b0}}};

    logic [TIME_W+VAL_W-1:0] mem [WINDOW_DEPTH];
    logic [TIME_W+VAL_W-1:0] r_rd;

    logic [TIME_W-1:0]        rd_t;
    logic signed [VAL_W-1:0]  rd_y;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [2*MUL_W-1:0] r_prod;

    logic [NUM_W-1:0]         r_acc_ty;
    logic [TT_W-1:0]          r_acc_tt;
    logic [SUMT_W-1:0]        r_acc_t;
    logic signed [SUMY_W-1:0] r_acc_y;
    logic [NUM_W-1:0]         r_cross;
    logic [DEN_W-1:0]         r_sq;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den;

    logic                     r_neg;
    logic [DVD_W-1:0]         r_q;
    logic [DEN_W:0]           r_rem;
    logic [DEN_W:0]           rem_sh;
    logic                     rem_ge;
    logic [NUM_W-1:0]         mag;

    logic signed [SLOPE_W-1:0] r_slope;
    logic                      r_full;
    logic                      r_degen;
    logic [SLOPE_W-1:0]        sat;

    logic [MUL_W-1:0] t_ext, t_lo, t_hi, y_sum;

    assign rd_t  = r_rd[TIME_W-1:0];
    assign rd_y  = r_rd[TIME_W+VAL_W-1:TIME_W];
    assign t_ext = {1'b0, rd_t};
    assign t_lo  = {1'b0, r_acc_t[TIME_W-1:0]};
    assign t_hi  = {{(MUL_W-HI_W){1'b0}}, r_acc_t[SUMT_W-1:TIME_W]};
    assign y_sum = {{(MUL_W-SUMY_W){r_acc_y[SUMY_W-1]}}, r_acc_y};

    always_comb begin
        mul_a = signed'(t_ext);
        mul_b = signed'(t_ext);
        case (i_cmd.op)
            OP_MUL_TY: mul_b = {{(MUL_W-VAL_W){rd_y[VAL_W-1]}}, rd_y};
            OP_X_LO: begin
                mul_a = signed'(y_sum);
                mul_b = signed'(t_lo);
            end
            OP_X_HI: begin
                mul_a = signed'(y_sum);
                mul_b = signed'(t_hi);
            end
            OP_SQ_LL: begin
                mul_a = signed'(t_lo);
                mul_b = signed'(t_lo);
            end
            OP_SQ_HL: begin
                mul_a = signed'(t_hi);
                mul_b = signed'(t_lo);
            end
            OP_SQ_HH: begin
                mul_a = signed'(t_hi);
                mul_b = signed'(t_hi);
            end
            default: ;
        endcase
    end

    // Restoring division step: shift in the next dividend bit and trial-subtract.
    assign rem_sh     = {r_rem[DEN_W-1:0], r_q[DVD_W-1]};
    assign rem_ge     = rem_sh >= {1'b0, r_den};
    assign o_den_zero = (r_den == '0);
    assign mag        = r_num[NUM_W-1] ? (~r_num + 1'b1) : r_num;

    always_comb begin
        if (r_neg) begin
            if ((r_q[DVD_W-1:SLOPE_W] != '0) ||
                (r_q[SLOPE_W-1] && (r_q[SLOPE_W-2:0] != '0))) begin
                sat = NEG_MAX;
            end else begin
                sat = ~r_q[SLOPE_W-1:0] + 1'b1;
            end
        end else begin
            if (r_q[DVD_W-1:SLOPE_W-1] != '0) begin
                sat = POS_MAX;
            end else begin
                sat = r_q[SLOPE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE) begin
            mem[i_addr] <= {i_value, i_time};
        end
        if (i_cmd.op == OP_READ) begin
            r_rd <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_WRITE: begin
                r_acc_ty <= '0;
                r_acc_tt <= '0;
                r_acc_t  <= '0;
                r_acc_y  <= '0;
            end
            OP_MUL_TT: r_acc_ty <= r_acc_ty + r_prod[NUM_W-1:0];
            OP_ACC: begin
                r_acc_tt <= r_acc_tt + TT_W'(r_prod[NUM_W-1:0]);
                r_acc_t  <= r_acc_t + SUMT_W'(rd_t);
                r_acc_y  <= r_acc_y + {{(SUMY_W-VAL_W){rd_y[VAL_W-1]}}, rd_y};
            end
            OP_X_HI:  r_cross <= r_prod[NUM_W-1:0];
            OP_SQ_LL: r_cross <= r_cross + {r_prod[NUM_W-TIME_W-1:0], {TIME_W{1'b0}}};
            OP_SQ_HL: r_sq <= DEN_W'(r_prod[NUM_W-1:0]);
            OP_SQ_HH: r_sq <= r_sq + (DEN_W'(r_prod[NUM_W-1:0]) << (TIME_W + 1));
            OP_NUM: begin
                r_sq  <= r_sq + (DEN_W'(r_prod[NUM_W-1:0]) << (2 * TIME_W));
                r_num <= NUM_W'(r_acc_ty * NUM_W'(WINDOW_DEPTH)) - r_cross;
            end
            OP_DEN: r_den <= DEN_W'(DEN_W'(r_acc_tt) * DEN_W'(WINDOW_DEPTH)) - r_sq;
            OP_DIV_LOAD: begin
                r_neg <= r_num[NUM_W-1];
                r_q   <= {mag, {FRAC_W{1'b0}}};
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= rem_ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_q   <= {r_q[DVD_W-2:0], rem_ge};
            end
            OP_RES_ZERO: begin
                r_slope <= '0;
                r_full  <= i_cmd.full;
                r_degen <= 1'b0;
            end
            OP_RES_DEGEN: begin
                r_slope <= '0;
                r_full  <= i_cmd.full;
                r_degen <= 1'b1;
            end
            OP_RES_SLOPE: begin
                r_slope <= signed'(sat);
                r_full  <= i_cmd.full;
                r_degen <= 1'b0;
            end
            default: ;
        endcase
    end

    assign o_slope = r_slope;
    assign o_full  = r_full;
    assign o_degen = r_degen;

endmodule

[sv/sliding_window_slope.sv]
// Top level of the sliding window least-squares slope block.
//
// Input words arrive on the slave stream: tdata carries the timestamp and the
// sample, tuser carries the opcode (insert or clear). Each accepted word gives
// exactly one result word on the master stream: the slope in Q.16 on tdata,
// the window-full and zero-spread flags on tuser.
// A clear word, or an insert that leaves the window still short of full,
// goes straight to the result state. An insert over a full window, or the
// one that fills it, first runs each window entry through a read, two
// products and an accumulate on one shared 33x33 multiplier, then forms the
// cross and square products, numerator and denominator, and runs an 80-step restoring divider. One word is in work at
// a time; the next input word is taken as soon as the result is parked in the
// output register, even while the receiver has not yet taken it.
// When the receiver stalls, the result stays in the output register and a
// following result waits in the controller until that register frees up.
// Reset empties the window, clears the write index and the full flag, and
// drops the output valid; stored window contents are not cleared, since the
// slope is only formed over entries written after the last clear.
module sliding_window_slope #(
    parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // sample_time [31:0], sample_value [47:32]
    input  logic [0:0]  i_s_tuser,   // opcode [0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // slope_value [47:0]
    output logic [1:0]  o_m_tuser    // window_full [0], degenerate [1]
);
    import sws_pkg::*;

    t_dp_cmd                          cmd;
    logic [$clog2(WINDOW_DEPTH)-1:0]  addr;
    logic                             den_zero;
    logic signed [SLOPE_W-1:0]        slope;
    logic                             full;
    logic                             degen;

    sws_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_in_clear  (i_s_tuser[0]),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_den_zero  (den_zero),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    sws_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_addr     (addr),
        .i_time     (i_s_tdata[TIME_W-1:0]),
        .i_value    (signed'(i_s_tdata[TIME_W+VAL_W-1:TIME_W])),
        .o_den_zero (den_zero),
        .o_slope    (slope),
        .o_full     (full),
        .o_degen    (degen)
    );

    assign o_m_tdata = slope;
    assign o_m_tuser = {degen, full};

endmodule

[bench/tb_sliding_window_slope.sv]
// Self-checking testbench for the sliding window least-squares slope block.
`timescale 1ns / 100ps

module tb_sliding_window_slope;

    localparam int DEPTH      = sws_pkg::WINDOW_DEPTH_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 400;

    typedef enum bit {CMD_INSERT = 1'b0, CMD_CLEAR = 1'b1} t_cmd;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] stamp;
        logic [15:0] value;
        bit          drain;   // hold this word until all results are back
    } t_word;

    typedef struct {
        logic [47:0] slope;
        logic        full;
        logic        degen;
    } t_slope_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;   // sample_time [31:0], sample_value [47:32]
    logic [0:0]  i_s_tuser = '0;   // opcode [0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;        // slope_value [47:0]
    logic [1:0]  o_m_tuser;        // window_full [0], degenerate [1]

    t_word       pending_words[$];
    t_slope_res  slope_fifo[$];
    t_word       cur_word;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          words_in = 0;
    int          results_out = 0;
    int          idle_cycles = 0;
    int          err_count = 0;
    bit          long_hold_done = 0;

    // Mirror of the block's window.
    logic [31:0] stamp_win[DEPTH];
    logic [15:0] value_win[DEPTH];
    int          wr_slot = 0;
    bit          win_full = 0;

    sliding_window_slope uut (.*);

    always #1 i_clk = ~i_clk;

    function automatic int idle_max(int n);
        // A middle stretch of the run goes with no idling at all.
        return (n >= 700 && n < 1000) ? 0 : 10;
    endfunction

    function automatic t_slope_res window_slope(t_word w);
        t_slope_res  r;
        longint      dt, dy;
        logic [63:0] num, adt, mag;
        logic [127:0] den, quo;
        r = '{slope: '0, full: 1'b0, degen: 1'b0};
        if (w.cmd == CMD_CLEAR) begin
            foreach (stamp_win[k]) begin
                stamp_win[k] = '0;
                value_win[k] = '0;
            end
            wr_slot = 0;
            win_full = 0;
            return r;
        end
        stamp_win[wr_slot] = w.stamp;
        value_win[wr_slot] = w.value;
        wr_slot++;
        if (wr_slot == DEPTH) begin
            wr_slot = 0;
            win_full = 1;
        end
        if (!win_full) return r;
        r.full = 1'b1;
        num = '0;
        den = '0;
        for (int i = 0; i < DEPTH; i++) begin
            for (int j = i + 1; j < DEPTH; j++) begin
                dt = longint'(stamp_win[i]) - longint'(stamp_win[j]);
                dy = longint'($signed(value_win[i])) - longint'($signed(value_win[j]));
                num += dt * dy;
                adt = (dt < 0) ? -dt : dt;
                den += adt * adt;
            end
        end
        if (den == 0) begin
            r.degen = 1'b1;
            return r;
        end
        mag = num[63] ? -num : num;
        quo = {48'b0, mag, 16'b0} / den;
        if (num[63])
            r.slope = (quo > 128'h8000_0000_0000) ? 48'h8000_0000_0000 : -quo[47:0];
        else
            r.slope = (quo > 128'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : quo[47:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR result %0d: %s", results_out, what);
        err_count++;
    endtask

    // Sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                slope_fifo.push_back(window_slope(cur_word));
                words_in++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0 &&
                             !(pending_words[0].drain && slope_fifo.size() > 0)) begin
                    cur_word = pending_words.pop_front();
                    i_s_tdata <= {cur_word.value, cur_word.stamp};
                    i_s_tuser <= cur_word.cmd;
                    i_s_tvalid <= 1'b1;
                    send_gap = $urandom_range(0, idle_max(words_in));
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker.
    always @(posedge i_clk) begin
        t_slope_res exp_r;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (slope_fifo.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    exp_r = slope_fifo.pop_front();
                    if (o_m_tdata !== exp_r.slope)
                        report_mismatch($sformatf("slope %h, expected %h",
                                                  o_m_tdata, exp_r.slope));
                    if (o_m_tuser[0] !== exp_r.full)
                        report_mismatch($sformatf("window_full %b, expected %b",
                                                  o_m_tuser[0], exp_r.full));
                    if (o_m_tuser[1] !== exp_r.degen)
                        report_mismatch($sformatf("degenerate %b, expected %b",
                                                  o_m_tuser[1], exp_r.degen));
                end
                results_out++;
                if (results_out == 300 && !long_hold_done) begin
                    long_hold_done = 1;
                    recv_gap = LONG_HOLD;
                end else begin
                    recv_gap = $urandom_range(0, idle_max(results_out));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sliding_window_slope: mismatch");
            $finish;
        end
    end

    task automatic add_word(t_cmd c, logic [31:0] s, logic [15:0] v, bit d = 0);
        pending_words.push_back('{cmd: c, stamp: s, value: v, drain: d});
    endtask

    initial begin
        int          run_len, mode;
        logic [31:0] base, step;
        int          slope_lsb;

        // Directed part: clear, a window of equal timestamps with extreme
        // values, then extreme timestamps pushed through the full window, and a draining clear with one insert.
        add_word(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
        for (int k = 0; k < DEPTH; k++)
            add_word(CMD_INSERT, 32'd5, k[0] ? 16'h7FFF : 16'h8000);
        add_word(CMD_INSERT, 32'd0, 16'h8000);
        add_word(CMD_INSERT, 32'hFFFF_FFFF, 16'h7FFF);
        add_word(CMD_INSERT, 32'd1, 16'h0000);
        add_word(CMD_INSERT, 32'hFFFF_FFFE, 16'hFFFF);
        add_word(CMD_CLEAR, 32'd0, 16'd0, 1);
        add_word(CMD_INSERT, 32'h8000_0000, 16'h0001);

        // Random part: mostly windows of structured data, some noise.
        while (pending_words.size() < 1770) begin
            run_len = $urandom_range(4, 40);
            mode = $urandom_range(0, 4);
            base = $urandom;
            step = (mode == 1) ? $urandom_range(1, 4) : $urandom_range(0, 2000);
            slope_lsb = $urandom_range(0, 200) - 100;
            for (int k = 0; k < run_len; k++) begin
                case (mode)
                    0: add_word(CMD_INSERT, $urandom, 16'($urandom));
                    2: add_word(CMD_INSERT, base, 16'($urandom));
                    3: add_word(CMD_INSERT, base + $urandom_range(0, 3), 16'($urandom));
                    default: add_word(CMD_INSERT, base + k * step,
                                      16'(slope_lsb * k + $urandom_range(0, 15)));
                endcase
            end
            if ($urandom_range(0, 5) == 0)
                add_word(CMD_CLEAR, $urandom, 16'($urandom), $urandom_range(0, 3) == 0);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_words.size() == 0 && !i_s_tvalid && slope_fifo.size() == 0);
        repeat (200) @(posedge i_clk);
        if (err_count == 0 && slope_fifo.size() == 0)
            $display("sliding_window_slope: match");
        else
            $display("sliding_window_slope: mismatch");
        $finish;
    end

endmodule
